// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the complex bin mean accumulator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/cbma_pkg.sv =====
// Package for the complex bin mean accumulator: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
package cbma_pkg;

    localparam int MAX_LAYERS  = 32;
    localparam int MAX_HEADS   = 32;
    localparam int MAX_FREQS   = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int LAYER_W  = 5;
    localparam int HEAD_W   = 5;
    localparam int DIM_W    = 7;
    localparam int FREQ_W   = $clog2(MAX_FREQS);
    localparam int ADDR_W   = LAYER_W + HEAD_W + FREQ_W;
    localparam int BIN_COUNT = 2 ** ADDR_W;
    localparam int SUM_W    = 48;
    localparam int TOK_W    = 32;
    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = SUM_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [1:0] CFG_SPLIT_HALF = 2'd0;
    localparam logic [1:0] CFG_NUM_LAYERS = 2'd1;
    localparam logic [1:0] CFG_NUM_HEADS  = 2'd2;
    localparam logic [1:0] CFG_FREQ_COUNT = 2'd3;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2,
        OP_RSV   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_NO_TOKENS = 2'd2,
        ST_NOT_PAIR  = 2'd3
    } t_status;

    typedef struct packed {
        logic              take;
        logic              clear_wr;
        logic [ADDR_W-1:0] clear_addr;
        logic              rd_en;
        logic              tok_inc;
        logic              root_load;
        logic              root_step;
        logic              acc_wr;
        logic              div_load;
        logic              div_step;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        t_status code;
        t_op     op;
        logic    out_free;
    } t_stat;

endpackage

// ===== src/cbma_ctrl.sv =====
// Controller of the complex bin mean accumulator: sequences the clearing
// pass, the square-root and division iterations. Depends on cbma_pkg.
module cbma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cbma_pkg::t_stat i_stat,
    output cbma_pkg::t_cmd  o_cmd,
    output logic           o_stall
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_ROOT, S_WRITE, S_LOAD, S_DIV, S_DONE
    } t_state;

    t_state                       r_state;
    logic [cbma_pkg::CNT_W-1:0]   r_cnt;
    logic [cbma_pkg::ADDR_W-1:0]  r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_cnt <= '0;
                    if (i_stat.code != cbma_pkg::ST_OK) begin
                        r_state <= S_DONE;
                    end else if (i_stat.op == cbma_pkg::OP_ACC) begin
                        r_state <= S_ROOT;
                    end else if (i_stat.op == cbma_pkg::OP_READ) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == cbma_pkg::CNT_W'(cbma_pkg::ROOT_STEPS - 1))
                        r_state <= S_WRITE;
                end
                S_WRITE: r_state <= S_DONE;
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == cbma_pkg::CNT_W'(cbma_pkg::DIV_STEPS - 1))
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.take       = (r_state == S_IDLE) && i_valid;
        o_cmd.clear_wr   = (r_state == S_CLEAR);
        o_cmd.clear_addr = r_clr;
        o_cmd.rd_en      = (r_state == S_CHECK);
        o_cmd.root_load  = (r_state == S_CHECK);
        o_cmd.tok_inc    = (r_state == S_CHECK) && (i_stat.code == cbma_pkg::ST_OK)
                           && (i_stat.op == cbma_pkg::OP_COUNT);
        o_cmd.root_step  = (r_state == S_ROOT);
        o_cmd.acc_wr     = (r_state == S_WRITE);
        o_cmd.div_load   = (r_state == S_LOAD);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.out_load   = (r_state == S_DONE) && i_stat.out_free;
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== src/cbma_dp.sv =====
// Datapath of the complex bin mean accumulator: configuration, bin memory,
// square-root and divider units, output register. Depends on cbma_pkg.
module cbma_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cbma_pkg::t_cmd                       i_cmd,
    output cbma_pkg::t_stat                      o_stat,
    input  logic                                 i_cfg_wr_en,
    input  logic [1:0]                           i_cfg_index,
    input  logic [6:0]                           i_cfg_data,
    input  logic [1:0]                           i_operation,
    input  logic [cbma_pkg::LAYER_W-1:0]         i_layer,
    input  logic [cbma_pkg::HEAD_W-1:0]          i_head,
    input  logic [cbma_pkg::DIM_W-1:0]           i_dim_index,
    input  logic signed [cbma_pkg::SAMPLE_BITS-1:0] i_real_value,
    input  logic signed [cbma_pkg::SAMPLE_BITS-1:0] i_imag_value,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic signed [15:0]                   o_mean_real,
    output logic signed [15:0]                   o_mean_imag,
    output logic [15:0]                          o_mean_magnitude,
    output logic [cbma_pkg::TOK_W-1:0]           o_tokens_seen
);

    localparam int SW = cbma_pkg::SUM_W;
    localparam int TW = cbma_pkg::TOK_W;
    localparam int QW = cbma_pkg::SQ_W;
    localparam int BW = cbma_pkg::SAMPLE_BITS;

    // configuration
    logic       r_split_half;
    logic [5:0] r_num_layers;
    logic [5:0] r_num_heads;
    logic [6:0] r_freq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_half <= 1'b1;
            r_num_layers <= 6'd32;
            r_num_heads  <= 6'd32;
            r_freq_count <= 7'd64;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cbma_pkg::CFG_SPLIT_HALF: r_split_half <= i_cfg_data[0];
                cbma_pkg::CFG_NUM_LAYERS: r_num_layers <= i_cfg_data[5:0];
                cbma_pkg::CFG_NUM_HEADS:  r_num_heads  <= i_cfg_data[5:0];
                cbma_pkg::CFG_FREQ_COUNT: r_freq_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured transaction
    cbma_pkg::t_op               r_op;
    logic [cbma_pkg::LAYER_W-1:0] r_layer;
    logic [cbma_pkg::HEAD_W-1:0]  r_head;
    logic [cbma_pkg::DIM_W-1:0]   r_dim;
    logic signed [BW-1:0]         r_real;
    logic signed [BW-1:0]         r_imag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= cbma_pkg::t_op'(i_operation);
            r_layer <= i_layer;
            r_head  <= i_head;
            r_dim   <= i_dim_index;
            r_real  <= i_real_value;
            r_imag  <= i_imag_value;
        end
    end

    // token counter
    logic [TW-1:0] r_tokens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens <= '0;
        end else if (i_cmd.tok_inc && (r_layer == '0) && (r_tokens != '1)) begin
            r_tokens <= r_tokens + 1'b1;
        end
    end

    // range checks and bin address
    logic [6:0]                  w_fc;
    logic [7:0]                  w_two_fc;
    logic                        w_layer_ok;
    logic                        w_head_ok;
    logic [cbma_pkg::FREQ_W-1:0] w_freq;
    cbma_pkg::t_status           w_code;
    logic [cbma_pkg::ADDR_W-1:0] w_addr;

    assign w_fc       = (r_freq_count > 7'(cbma_pkg::MAX_FREQS))
                        ? 7'(cbma_pkg::MAX_FREQS) : r_freq_count;
    assign w_two_fc   = {w_fc, 1'b0};
    assign w_layer_ok = {1'b0, r_layer} < r_num_layers;
    assign w_head_ok  = {1'b0, r_head} < r_num_heads;

    always_comb begin
        w_code = cbma_pkg::ST_OK;
        if (r_op == cbma_pkg::OP_RSV || !w_layer_ok) begin
            w_code = cbma_pkg::ST_BAD_INDEX;
        end else if (r_op == cbma_pkg::OP_COUNT) begin
            w_code = cbma_pkg::ST_OK;
        end else if (!w_head_ok) begin
            w_code = cbma_pkg::ST_BAD_INDEX;
        end else if (r_op == cbma_pkg::OP_ACC) begin
            if ({1'b0, r_dim} >= w_two_fc)
                w_code = cbma_pkg::ST_BAD_INDEX;
            else if (r_split_half && (r_dim >= w_fc))
                w_code = cbma_pkg::ST_NOT_PAIR;
            else if (!r_split_half && r_dim[0])
                w_code = cbma_pkg::ST_NOT_PAIR;
        end else begin
            if (r_dim >= w_fc)
                w_code = cbma_pkg::ST_BAD_INDEX;
            else if (r_tokens == '0)
                w_code = cbma_pkg::ST_NO_TOKENS;
        end
    end

    assign w_freq = (r_op == cbma_pkg::OP_ACC && !r_split_half)
                    ? r_dim[cbma_pkg::FREQ_W:1] : r_dim[cbma_pkg::FREQ_W-1:0];
    assign w_addr = {r_layer, r_head, w_freq};

    // integer square root, two bits of the radicand per step
    logic [QW-1:0] r_sq_x;
    logic [QW-1:0] r_root;
    logic [QW-1:0] r_bit;
    logic signed [QW-1:0] w_sq_r;
    logic signed [QW-1:0] w_sq_i;
    logic [QW:0]   w_trial;

    assign w_sq_r  = r_real * r_real;
    assign w_sq_i  = r_imag * r_imag;
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_load) begin
            r_sq_x <= $unsigned(w_sq_r) + $unsigned(w_sq_i);
            r_root <= '0;
            r_bit  <= QW'(1) << (QW - 2);
        end else if (i_cmd.root_step) begin
            if ({1'b0, r_sq_x} >= w_trial) begin
                r_sq_x <= r_sq_x - w_trial[QW-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // bin memory: real sum, imaginary sum, magnitude sum
    logic [3*SW-1:0] mem [cbma_pkg::BIN_COUNT];
    logic [3*SW-1:0] r_rd_data;
    logic [3*SW-1:0] w_wr_data;
    logic [cbma_pkg::ADDR_W-1:0] w_wr_addr;
    logic [15:0]     w_root;

    assign w_root    = r_root[15:0];
    assign w_wr_addr = i_cmd.clear_wr ? i_cmd.clear_addr : w_addr;
    assign w_wr_data = i_cmd.clear_wr ? '0 :
        { r_rd_data[3*SW-1:2*SW] + {{(SW-BW){r_real[BW-1]}}, r_real},
          r_rd_data[2*SW-1:SW]   + {{(SW-BW){r_imag[BW-1]}}, r_imag},
          r_rd_data[SW-1:0]      + {{(SW-16){1'b0}}, w_root} };

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr || i_cmd.acc_wr) mem[w_wr_addr] <= w_wr_data;
        if (i_cmd.rd_en) r_rd_data <= mem[w_addr];
    end

    // three restoring divider lanes, one quotient bit per step;
    // the quotient shifts into the dividend register
    logic [SW-1:0] r_num [3];
    logic [TW-1:0] r_rem [3];
    logic [1:0]    r_neg;
    logic [SW-1:0] n_num [3];
    logic [TW-1:0] n_rem [3];

    always_comb begin
        logic [TW:0] v_part;
        logic        v_ge;
        for (int k = 0; k < 3; k++) begin
            v_part   = {r_rem[k], r_num[k][SW-1]};
            v_ge     = v_part >= {1'b0, r_tokens};
            n_rem[k] = v_ge ? TW'(v_part - {1'b0, r_tokens}) : v_part[TW-1:0];
            n_num[k] = {r_num[k][SW-2:0], v_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg[0] <= r_rd_data[3*SW-1];
            r_neg[1] <= r_rd_data[2*SW-1];
            r_num[0] <= r_rd_data[3*SW-1] ? SW'(0) - r_rd_data[3*SW-1:2*SW]
                                          : r_rd_data[3*SW-1:2*SW];
            r_num[1] <= r_rd_data[2*SW-1] ? SW'(0) - r_rd_data[2*SW-1:SW]
                                          : r_rd_data[2*SW-1:SW];
            r_num[2] <= r_rd_data[SW-1:0];
            for (int k = 0; k < 3; k++) r_rem[k] <= '0;
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

    function automatic logic [15:0] sat_signed(input logic [SW-1:0] q, input logic neg);
        logic [15:0] v_res;
        if (neg) begin
            v_res = (q > SW'(32768)) ? 16'h8000 : 16'd0 - q[15:0];
        end else begin
            v_res = (q > SW'(32767)) ? 16'h7FFF : q[15:0];
        end
        return v_res;
    endfunction

    // output register
    logic            r_o_valid;
    logic [1:0]      r_status;
    logic [15:0]     r_mean_real;
    logic [15:0]     r_mean_imag;
    logic [15:0]     r_mean_mag;
    logic [TW-1:0]   r_tok_out;
    logic            w_has_means;

    assign w_has_means = (r_op == cbma_pkg::OP_READ) && (w_code == cbma_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status    <= w_code;
            r_tok_out   <= r_tokens;
            r_mean_real <= w_has_means ? sat_signed(r_num[0], r_neg[0]) : '0;
            r_mean_imag <= w_has_means ? sat_signed(r_num[1], r_neg[1]) : '0;
            r_mean_mag  <= !w_has_means ? '0 :
                           (r_num[2] > SW'(65535)) ? 16'hFFFF : r_num[2][15:0];
        end
    end

    assign o_stat.code     = w_code;
    assign o_stat.op       = r_op;
    assign o_stat.out_free = !r_o_valid || !i_stall;

    assign o_valid          = r_o_valid;
    assign o_status         = r_status;
    assign o_mean_real      = r_mean_real;
    assign o_mean_imag      = r_mean_imag;
    assign o_mean_magnitude = r_mean_mag;
    assign o_tokens_seen    = r_tok_out;

endmodule

// ===== src/complex_bin_mean_accumulator_unit.sv =====
// Complex bin mean accumulator, top level. Each accepted transaction is range
// checked; accumulate then runs 16 square-root steps and a bin write, read runs
// 48 divider steps; count and rejects skip both. One transaction at a time.
// Reset: synchronous, active low; registers return to their defaults and a
// clearing pass over all 65536 bins zeroes the bin memory before input is taken.
// Depends on cbma_pkg, cbma_ctrl, cbma_dp and assert_macros.svh.
`include "assert_macros.svh"

module complex_bin_mean_accumulator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_wr_en,
    input  logic [1:0]                           i_cfg_index,
    input  logic [6:0]                           i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_operation,
    input  logic [cbma_pkg::LAYER_W-1:0]         i_layer,
    input  logic [cbma_pkg::HEAD_W-1:0]          i_head,
    input  logic [cbma_pkg::DIM_W-1:0]           i_dim_index,
    input  logic signed [cbma_pkg::SAMPLE_BITS-1:0] i_real_value,
    input  logic signed [cbma_pkg::SAMPLE_BITS-1:0] i_imag_value,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [1:0]                           o_status,
    output logic signed [15:0]                   o_mean_real,
    output logic signed [15:0]                   o_mean_imag,
    output logic [15:0]                          o_mean_magnitude,
    output logic [cbma_pkg::TOK_W-1:0]           o_tokens_seen
);

    // The controller walks each transaction through a range check, then
    // either the square-root iterations and a read-modify-write of the bin,
    // or the divider iterations that form the three means. The result sits
    // in an output register, so the next transaction is accepted while an
    // earlier result still waits to be taken.
    cbma_pkg::t_cmd  w_cmd;
    cbma_pkg::t_stat w_stat;

    cbma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    // The datapath holds the configuration, the token counter, the bin
    // memory (real, imaginary and magnitude sums side by side in one word)
    // and the arithmetic units.
    cbma_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_layer          (i_layer),
        .i_head           (i_head),
        .i_dim_index      (i_dim_index),
        .i_real_value     (i_real_value),
        .i_imag_value     (i_imag_value),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_mean_real      (o_mean_real),
        .o_mean_imag      (o_mean_imag),
        .o_mean_magnitude (o_mean_magnitude),
        .o_tokens_seen    (o_tokens_seen)
    );

    // An accepted transaction closes the input until its result is formed.
    `ASSERT_PROP(a_busy_after_take, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    // A new result never overwrites one still waiting at the output.
    `ASSERT_PROP(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load |-> (!o_valid || !i_stall))
    // The clearing pass and a bin update never share the write port.
    `ASSERT_NEVER(a_one_writer, i_clk, i_rst_n, w_cmd.clear_wr && w_cmd.acc_wr)

endmodule

// ===== tb/cbma_scoreboard.sv =====
// Checker for the complex bin mean accumulator: watches the configuration port
// and both channels, predicts each result and compares it with the block.
// Depends on cbma_pkg.
module cbma_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_layer,
    input  logic [4:0]  i_head,
    input  logic [6:0]  i_dim_index,
    input  logic [15:0] i_real_value,
    input  logic [15:0] i_imag_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_mean_real,
    input  logic [15:0] i_mean_imag,
    input  logic [15:0] i_mean_magnitude,
    input  logic [31:0] i_tokens_seen,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] mean_re;
        logic [15:0] mean_im;
        logic [15:0] mean_mag;
        logic [31:0] tokens;
    } t_bin_result;

    logic [47:0] re_sum  [0:65535];
    logic [47:0] im_sum  [0:65535];
    logic [47:0] mag_sum [0:65535];
    logic [31:0] tokens_so_far;
    logic        pair_split;
    logic [5:0]  layer_lim;
    logic [5:0]  head_lim;
    logic [6:0]  freq_lim;
    t_bin_result awaited[$];

    assign o_pending = awaited.size();

    initial begin
        o_errors = 0;
        for (int k = 0; k < 65536; k++) begin
            re_sum[k] = '0;
            im_sum[k] = '0;
            mag_sum[k] = '0;
        end
    end

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [15:0] mean_of_signed(logic [47:0] sum, logic [31:0] tok);
        longint s;
        longint unsigned m;
        longint unsigned q;
        s = longint'({{16{sum[47]}}, sum});
        m = (s < 0) ? longint'(-s) : s;
        q = m / tok;
        if (s < 0) begin
            if (q > 32768) q = 32768;
            return 16'(-q);
        end
        if (q > 32767) q = 32767;
        return 16'(q);
    endfunction

    // Applies one transaction to the shadow bins and returns what the block must send.
    function automatic t_bin_result apply_transaction(logic [1:0] op, logic [4:0] lay,
            logic [4:0] hd, logic [6:0] dim, logic [15:0] re, logic [15:0] im);
        t_bin_result res;
        int nl, nh, fc, f, bin;
        longint rv, iv;
        longint unsigned q;
        logic [47:0] mag;
        nl = (layer_lim > cbma_pkg::MAX_LAYERS) ? cbma_pkg::MAX_LAYERS : layer_lim;
        nh = (head_lim > cbma_pkg::MAX_HEADS) ? cbma_pkg::MAX_HEADS : head_lim;
        fc = (freq_lim > cbma_pkg::MAX_FREQS) ? cbma_pkg::MAX_FREQS : freq_lim;
        res = '0;
        f = 0;
        if (op == cbma_pkg::OP_RSV || lay >= nl) begin
            res.status = cbma_pkg::ST_BAD_INDEX;
        end else if (op == cbma_pkg::OP_COUNT) begin
            if (lay == 0 && tokens_so_far != 32'hFFFF_FFFF) tokens_so_far++;
        end else if (hd >= nh) begin
            res.status = cbma_pkg::ST_BAD_INDEX;
        end else if (op == cbma_pkg::OP_ACC) begin
            if (dim >= 2 * fc) res.status = cbma_pkg::ST_BAD_INDEX;
            else if (pair_split) begin
                if (dim >= fc) res.status = cbma_pkg::ST_NOT_PAIR;
                else f = dim;
            end else begin
                if (dim[0]) res.status = cbma_pkg::ST_NOT_PAIR;
                else f = dim >> 1;
            end
            if (res.status == cbma_pkg::ST_OK) begin
                rv = longint'(signed'(re));
                iv = longint'(signed'(im));
                mag = 48'(root_floor(rv * rv + iv * iv));
                bin = (lay * cbma_pkg::MAX_HEADS + hd) * cbma_pkg::MAX_FREQS + f;
                re_sum[bin] = re_sum[bin] + 48'(rv);
                im_sum[bin] = im_sum[bin] + 48'(iv);
                mag_sum[bin] = mag_sum[bin] + mag;
            end
        end else begin
            if (dim >= fc) res.status = cbma_pkg::ST_BAD_INDEX;
            else if (tokens_so_far == 0) res.status = cbma_pkg::ST_NO_TOKENS;
            else begin
                bin = (lay * cbma_pkg::MAX_HEADS + hd) * cbma_pkg::MAX_FREQS + dim;
                res.mean_re = mean_of_signed(re_sum[bin], tokens_so_far);
                res.mean_im = mean_of_signed(im_sum[bin], tokens_so_far);
                q = mag_sum[bin] / tokens_so_far;
                res.mean_mag = (q > 65535) ? 16'hFFFF : 16'(q);
            end
        end
        res.tokens = tokens_so_far;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_bin_result want;
        if (!i_rst_n) begin
            tokens_so_far = '0;
            pair_split <= 1'b1;
            layer_lim <= 6'd32;
            head_lim <= 6'd32;
            freq_lim <= 7'd64;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    cbma_pkg::CFG_SPLIT_HALF: pair_split <= i_cfg_data[0];
                    cbma_pkg::CFG_NUM_LAYERS: layer_lim <= i_cfg_data[5:0];
                    cbma_pkg::CFG_NUM_HEADS:  head_lim <= i_cfg_data[5:0];
                    default:                  freq_lim <= i_cfg_data;
                endcase
            end
            if (i_valid && !i_in_stall)
                awaited.push_back(apply_transaction(i_operation, i_layer, i_head,
                                                    i_dim_index, i_real_value,
                                                    i_imag_value));
            if (i_out_valid && !i_out_stall) begin
                if (awaited.size() == 0) begin
                    $display("%0t: result with none awaited (status %0d)", $time, i_status);
                    o_errors++;
                end else begin
                    want = awaited.pop_front();
                    if (want !== {i_status, i_mean_real, i_mean_imag, i_mean_magnitude,
                                  i_tokens_seen}) begin
                        $display("%0t: expected st=%0d re=%h im=%h mag=%h tok=%0d", $time,
                                 want.status, want.mean_re, want.mean_im, want.mean_mag,
                                 want.tokens);
                        $display("%0t: actual   st=%0d re=%h im=%h mag=%h tok=%0d", $time,
                                 i_status, i_mean_real, i_mean_imag, i_mean_magnitude,
                                 i_tokens_seen);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/complex_bin_mean_accumulator_unit_test.sv =====
// Testbench top for the complex bin mean accumulator: drives directed and random
// transactions through several register settings; cbma_scoreboard does the checking.
// Depends on cbma_pkg, cbma_scoreboard and the block itself.
module complex_bin_mean_accumulator_unit_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = cbma_pkg::CFG_SPLIT_HALF;
    logic [6:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = cbma_pkg::OP_ACC;
    logic [4:0]  layer = '0;
    logic [4:0]  head = '0;
    logic [6:0]  dim = '0;
    logic [15:0] re_val = '0;
    logic [15:0] im_val = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] mean_re, mean_im, mean_mag;
    logic [31:0] tokens;
    int          errors;
    int          pending;

    // Shadow of the registers, used only to steer random transactions into range.
    int          sh_split = 1;
    int          sh_layers = 32;
    int          sh_heads = 32;
    int          sh_freqs = 64;
    // While set, neither side idles.
    bit          calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    complex_bin_mean_accumulator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_operation(op), .i_layer(layer), .i_head(head), .i_dim_index(dim),
        .i_real_value(re_val), .i_imag_value(im_val),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(status), .o_mean_real(mean_re), .o_mean_imag(mean_im),
        .o_mean_magnitude(mean_mag), .o_tokens_seen(tokens)
    );

    cbma_scoreboard i_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_operation(op), .i_layer(layer), .i_head(head), .i_dim_index(dim),
        .i_real_value(re_val), .i_imag_value(im_val),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_mean_real(mean_re), .i_mean_imag(mean_im),
        .i_mean_magnitude(mean_mag), .i_tokens_seen(tokens),
        .o_errors(errors), .o_pending(pending)
    );

    // The result side holds off now and then, except during the calm stretch.
    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end

    // Generous limit: the clearing pass plus roughly 600 transactions with stalls,
    // taken several times over.
    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Presents one transaction and holds it until the block takes it. A random
    // gap may go before it, with valid low.
    task automatic send_item(logic [1:0] o, logic [4:0] l, logic [4:0] h, logic [6:0] d,
                             logic [15:0] r, logic [15:0] m);
        if (!calm && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        op <= o;
        layer <= l;
        head <= h;
        dim <= d;
        re_val <= r;
        im_val <= m;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Lets every result come home and the block fall quiet.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            cbma_pkg::CFG_SPLIT_HALF: sh_split = val[0];
            cbma_pkg::CFG_NUM_LAYERS: sh_layers = val[5:0];
            cbma_pkg::CFG_NUM_HEADS:  sh_heads = val[5:0];
            default:                  sh_freqs = val;
        endcase
    endtask

    task automatic set_all(int sp, int nl, int nh, int fc);
        drain();
        write_reg(cbma_pkg::CFG_SPLIT_HALF, 7'(sp));
        write_reg(cbma_pkg::CFG_NUM_LAYERS, 7'(nl));
        write_reg(cbma_pkg::CFG_NUM_HEADS, 7'(nh));
        write_reg(cbma_pkg::CFG_FREQ_COUNT, 7'(fc));
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed transactions aimed at the bins in use, with some noise
    // across the whole field ranges.
    task automatic send_random(int count);
        int nl, nh, fc, sel;
        logic [1:0] o;
        logic [4:0] l, h;
        logic [6:0] d;
        for (int k = 0; k < count; k++) begin
            nl = (sh_layers > 32) ? 32 : ((sh_layers < 1) ? 1 : sh_layers);
            nh = (sh_heads > 32) ? 32 : ((sh_heads < 1) ? 1 : sh_heads);
            fc = (sh_freqs > 64) ? 64 : ((sh_freqs < 1) ? 1 : sh_freqs);
            sel = $urandom_range(0, 99);
            o = (sel < 50) ? cbma_pkg::OP_ACC : (sel < 68) ? cbma_pkg::OP_COUNT :
                (sel < 94) ? cbma_pkg::OP_READ : cbma_pkg::OP_RSV;
            l = 5'($urandom_range(0, nl - 1));
            h = 5'($urandom_range(0, nh - 1));
            if (o == cbma_pkg::OP_COUNT && $urandom_range(0, 9) < 7) l = '0;
            d = 7'($urandom_range(0, fc - 1));
            if (o == cbma_pkg::OP_ACC && !sh_split) d = 7'(2 * d);
            if ($urandom_range(0, 9) == 0) begin
                l = 5'($urandom);
                h = 5'($urandom);
                d = 7'($urandom);
            end else if (o == cbma_pkg::OP_ACC && $urandom_range(0, 9) == 0) begin
                d = 7'($urandom_range(0, (2 * fc + 1 > 127) ? 127 : 2 * fc + 1));
            end
            send_item(o, l, h, d, pick_sample(), pick_sample());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings: split-half pairs, full limits.
        send_item(cbma_pkg::OP_READ, 5'd0, 5'd0, 7'd0, '0, '0);            // no tokens yet
        send_item(cbma_pkg::OP_ACC, 5'd0, 5'd0, 7'd0, 16'h8000, 16'h8000);
        send_item(cbma_pkg::OP_ACC, 5'd0, 5'd0, 7'd0, 16'h7FFF, 16'h7FFF);
        send_item(cbma_pkg::OP_ACC, 5'd31, 5'd31, 7'd63, 16'h8000, 16'h7FFF);
        send_item(cbma_pkg::OP_ACC, 5'd31, 5'd31, 7'd63, 16'h8000, 16'h8000);
        send_item(cbma_pkg::OP_ACC, 5'd1, 5'd2, 7'd64, 16'h0100, 16'h0100);  // not a pair start
        send_item(cbma_pkg::OP_ACC, 5'd1, 5'd2, 7'd127, 16'h0100, 16'h0100); // also not a pair start
        send_item(cbma_pkg::OP_ACC, 5'd3, 5'd4, 7'd5, 16'h0000, 16'h0000);
        send_item(cbma_pkg::OP_RSV, 5'd0, 5'd0, 7'd0, 16'hFFFF, 16'hFFFF);   // unknown operation
        send_item(cbma_pkg::OP_COUNT, 5'd5, 5'd31, 7'd127, '0, '0);         // counts nothing
        send_item(cbma_pkg::OP_COUNT, 5'd0, 5'd0, 7'd0, '0, '0);
        send_item(cbma_pkg::OP_READ, 5'd0, 5'd0, 7'd0, '0, '0);             // magnitude mean saturates
        send_item(cbma_pkg::OP_READ, 5'd31, 5'd31, 7'd63, '0, '0);
        send_item(cbma_pkg::OP_READ, 5'd31, 5'd31, 7'd64, '0, '0);          // frequency too high
        send_item(cbma_pkg::OP_READ, 5'd3, 5'd4, 7'd5, '0, '0);
        send_item(cbma_pkg::OP_COUNT, 5'd0, 5'd9, 7'd1, '0, '0);
        send_item(cbma_pkg::OP_READ, 5'd0, 5'd0, 7'd0, '0, '0);

        // Interleaved pairs over a handful of bins.
        set_all(0, 2, 3, 4);
        send_item(cbma_pkg::OP_ACC, 5'd1, 5'd2, 7'd3, 16'h0100, 16'h0100);  // odd dim
        send_item(cbma_pkg::OP_ACC, 5'd1, 5'd2, 7'd8, 16'h0100, 16'h0100);  // beyond pairs
        send_item(cbma_pkg::OP_ACC, 5'd2, 5'd0, 7'd0, 16'h0100, 16'h0100);  // layer too high
        send_item(cbma_pkg::OP_ACC, 5'd0, 5'd3, 7'd0, 16'h0100, 16'h0100);  // head too high
        send_random(150);

        // Smallest settings.
        set_all(1, 1, 1, 1);
        send_random(60);

        // Register values above the limits act as the limits; no idling at first.
        set_all(0, 63, 63, 127);
        calm = 1'b1;
        send_random(100);
        calm = 1'b0;
        send_random(50);

        // Zero limits reject everything.
        set_all(1, 0, 0, 0);
        send_random(20);

        set_all(1, 3, 2, 5);
        send_random(100);
        drain();                 // sender holds off until every result is back
        send_random(120);

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== complex_bin_mean_accumulator_unit.f =====
+incdir+src
src/cbma_pkg.sv
src/cbma_ctrl.sv
src/cbma_dp.sv
src/complex_bin_mean_accumulator_unit.sv
tb/cbma_scoreboard.sv
tb/complex_bin_mean_accumulator_unit_test.sv
